// ===== src/slvm_pkg.sv =====
// Package for the speed limit violation monitor.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package slvm_pkg;

    localparam int SPEED_W = 10;
    localparam int TIMEOUT_W = 16;
    localparam int TPS_W = 16;
    localparam int SECONDS_W = 32;
    localparam int ALARM_W = TIMEOUT_W + TPS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 10'd120;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd0;
    localparam logic [TPS_W-1:0] TPS_RST = 16'd100;

    localparam logic [SECONDS_W-1:0] SECONDS_MAX = '1;

    typedef enum logic [1:0] {
        MODE_BELOW = 2'd0,
        MODE_WAITING = 2'd1,
        MODE_ABOVE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_limit_kmh;
        logic [TIMEOUT_W-1:0] violation_timeout_s;
        logic [TPS_W-1:0] ticks_per_second;
    } t_cfg;

    typedef struct packed {
        logic [1:0] speed_state;
        logic violation_started;
        logic violation_finished;
        logic [SECONDS_W-1:0] violation_seconds;
    } t_result;

endpackage

// ===== src/slvm_tick_if.sv =====
// Input channel of the speed limit violation monitor: one tick item.
// Depends on slvm_pkg.
interface slvm_tick_if;
    import slvm_pkg::*;

    logic valid;
    logic ready;
    logic [SPEED_W-1:0] speed_kmh;
    logic fix_valid;

    modport source(output valid, speed_kmh, fix_valid, input ready);
    modport sink(input valid, speed_kmh, fix_valid, output ready);
endinterface

// ===== src/slvm_result_if.sv =====
// Output channel of the speed limit violation monitor: one result item.
// Depends on slvm_pkg.
interface slvm_result_if;
    import slvm_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] speed_state;
    logic violation_started;
    logic violation_finished;
    logic [SECONDS_W-1:0] violation_seconds;

    modport source(output valid, speed_state, violation_started, violation_finished,
                   violation_seconds, input ready);
    modport sink(input valid, speed_state, violation_started, violation_finished,
                 violation_seconds, output ready);
endinterface

// ===== src/slvm_cfg.sv =====
// Configuration register file of the speed limit violation monitor.
// Depends on slvm_pkg.
module slvm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slvm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output slvm_pkg::t_cfg                  o_cfg
);
    import slvm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit_kmh <= SPEED_LIMIT_RST;
            r_cfg.violation_timeout_s <= TIMEOUT_RST;
            r_cfg.ticks_per_second <= TPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_LIMIT: begin
                    r_cfg.speed_limit_kmh <= i_cfg_wdata[SPEED_W-1:0];
                end
                CFG_TIMEOUT: begin
                    r_cfg.violation_timeout_s <= i_cfg_wdata[TIMEOUT_W-1:0];
                end
                CFG_TICKS_PER_SEC: begin
                    r_cfg.ticks_per_second <= i_cfg_wdata[TPS_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== src/slvm_core.sv =====
// Tick core of the speed limit violation monitor: timers, mode and total.
// Updates its state once per stepped item. Depends on slvm_pkg.
module slvm_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [slvm_pkg::SPEED_W-1:0] i_speed_kmh,
    input  logic                         i_fix_valid,
    input  slvm_pkg::t_cfg               i_cfg,
    output slvm_pkg::t_result            o_result
);
    import slvm_pkg::*;

    t_mode r_mode, n_mode;
    logic [ALARM_W-1:0] r_alarm, n_alarm;
    logic [TPS_W-1:0] r_second, n_second;
    logic [SECONDS_W-1:0] r_total, n_total;

    logic [ALARM_W-1:0] w_alarm_dec;
    logic [TPS_W-1:0] w_second_dec;
    logic [ALARM_W-1:0] w_alarm_load;
    logic [SECONDS_W-1:0] w_base;
    logic w_run;
    logic w_over;
    logic w_started;
    logic w_finished;

    assign w_alarm_dec = (r_alarm != '0) ? r_alarm - ALARM_W'(1) : '0;
    assign w_second_dec = (r_second != '0) ? r_second - TPS_W'(1) : '0;
    assign w_alarm_load = ALARM_W'(i_cfg.violation_timeout_s)
                        * ALARM_W'(i_cfg.ticks_per_second);
    assign w_run = i_fix_valid && (i_cfg.violation_timeout_s != '0);
    assign w_over = i_speed_kmh > i_cfg.speed_limit_kmh;
    // waiting: a drop back under the limit clears the total before the second is counted
    assign w_base = w_over ? r_total : '0;

    always_comb begin
        n_mode = r_mode;
        n_alarm = w_alarm_dec;
        n_second = w_second_dec;
        n_total = r_total;
        w_started = 1'b0;
        w_finished = 1'b0;
        if (w_run) begin
            unique case (r_mode)
                MODE_WAITING: begin
                    n_total = w_base;
                    if (!w_over) begin
                        n_mode = MODE_BELOW;
                    end else if (w_alarm_dec == '0) begin
                        w_started = 1'b1;
                        n_mode = MODE_ABOVE;
                    end
                    if (w_second_dec == '0) begin
                        n_total = (w_base == SECONDS_MAX) ? w_base : w_base + SECONDS_W'(1);
                        n_second = i_cfg.ticks_per_second;
                    end
                end
                MODE_ABOVE: begin
                    if (!w_over) begin
                        n_mode = MODE_BELOW;
                        w_finished = 1'b1;
                    end else if (w_second_dec == '0) begin
                        n_total = (r_total == SECONDS_MAX) ? r_total : r_total + SECONDS_W'(1);
                        n_second = i_cfg.ticks_per_second;
                    end
                end
                default: begin
                    n_mode = MODE_BELOW;
                    if (w_over) begin
                        n_alarm = w_alarm_load;
                        n_second = i_cfg.ticks_per_second;
                        n_mode = MODE_WAITING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BELOW;
            r_alarm <= '0;
            r_second <= TPS_RST;
            r_total <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_alarm <= n_alarm;
            r_second <= n_second;
            r_total <= n_total;
        end
    end

    assign o_result.speed_state = n_mode;
    assign o_result.violation_started = w_started;
    assign o_result.violation_finished = w_finished;
    assign o_result.violation_seconds = n_total;
endmodule

// ===== src/speed_limit_violation_monitor.sv =====
// Top level of the speed limit violation monitor.
// Input register, tick core, result register. Depends on slvm_pkg, the channel
// interfaces, slvm_cfg and slvm_core.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+---------------------------------------------
//   i_tick    | in  | valid / ready | speed_kmh, fix_valid
//   o_result  | out | valid / ready | speed_state, violation_started,
//             |     |               | violation_finished, violation_seconds
//   cfg       | in  | i_cfg_we      | i_cfg_idx, i_cfg_wdata
//
// One item per cycle sustained while the result is not stalled; the result is valid once
// the item has moved from the input register into the result register. The tick core
// updates all state in the same cycle that an item moves between these two registers.
// Reset clears both valid flags and loads the configuration registers and core state
// with their reset values. A stalled result holds; the input register keeps taking items
// as long as the result register can drain.
module speed_limit_violation_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slvm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    slvm_tick_if.sink                       i_tick,
    slvm_result_if.source                   o_result
);
    import slvm_pkg::*;

    t_cfg w_cfg;
    t_result w_core_result;
    t_result r_out;
    logic r_out_valid;
    logic r_in_valid;
    logic [SPEED_W-1:0] r_in_speed;
    logic r_in_fix;
    logic w_advance;
    logic w_step;

    slvm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (w_cfg)
    );

    slvm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_speed_kmh(r_in_speed),
        .i_fix_valid(r_in_fix),
        .i_cfg      (w_cfg),
        .o_result   (w_core_result)
    );

    assign w_advance = !r_out_valid || o_result.ready;
    assign w_step = r_in_valid && w_advance;
    assign i_tick.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_speed <= i_tick.speed_kmh;
            r_in_fix <= i_tick.fix_valid;
        end
        if (w_step) begin
            r_out <= w_core_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.speed_state = r_out.speed_state;
    assign o_result.violation_started = r_out.violation_started;
    assign o_result.violation_finished = r_out.violation_finished;
    assign o_result.violation_seconds = r_out.violation_seconds;
endmodule

// ===== src/slvm_chk.sv =====
// Port-level checks for the speed limit violation monitor, bound to the top level.
// Depends on slvm_pkg.
module slvm_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [1:0]                   i_speed_state,
    input logic                         i_started,
    input logic                         i_finished,
    input logic [slvm_pkg::SECONDS_W-1:0] i_seconds
);
    import slvm_pkg::*;

    // a start pulse always lands in the above-limit state
    a_started_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_started |-> i_speed_state == MODE_ABOVE)
        else $error("violation_started outside above-limit state");

    // a finish pulse always lands in the below-limit state
    a_finished_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_finished |-> i_speed_state == MODE_BELOW)
        else $error("violation_finished outside below-limit state");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_started && i_finished))
        else $error("start and finish pulses together");

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_speed_state) && $stable(i_started)
            && $stable(i_finished) && $stable(i_seconds))
        else $error("stalled result changed");
endmodule

bind speed_limit_violation_monitor slvm_chk u_slvm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_speed_state(o_result.speed_state),
    .i_started    (o_result.violation_started),
    .i_finished   (o_result.violation_finished),
    .i_seconds    (o_result.violation_seconds)
);
